/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication or plain property that must hold at every edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true out of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

/* rtl/dgpp_pkg.sv */
// ----------------------------------------------------------------------------
// Dithered gradient palette pick package
// Widths, codes, transaction structs, reciprocal tables and dither patterns.
// ----------------------------------------------------------------------------
package dgpp_pkg;

	localparam int DEFAULT_PALETTE_DEPTH = 16;
	localparam int SHADE_LEVELS          = 15;
	localparam int MIN_COLORS            = 2;

	localparam int COORD_W    = 16;
	localparam int DIST_W     = 24;
	localparam int COLOR_W    = 24;
	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 5;
	localparam int STEP_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Datapath widths, sized from the largest distance and colour count
	localparam int NUM_W     = 33;
	localparam int FRAC_W    = 16;
	localparam int RND_SHIFT = 15;
	localparam int T_W       = 17;
	localparam int M_W       = 17;
	localparam int IDX_W     = 13;
	localparam int LVL_W     = 4;

	// Reciprocal of the level step: floor(2^18 / step)
	localparam int STEP_RCP_K = 18;
	localparam int STEP_RCP_W = 19;
	// Reciprocal of fifteen: ceil(2^21 / 15), exact for the whole range of m
	localparam int INV15_K = 21;
	localparam int INV15_W = 18;
	localparam logic [INV15_W-1:0] INV15 = 18'd139811;
	localparam int P_W = M_W + INV15_W;
	// Reciprocal of the wrap length: floor(2^13 / d)
	localparam int WRAP_RCP_K = 13;
	localparam int WRAP_RCP_W = 14;

	localparam logic [CNT_W-1:0]  RESET_COLOR_COUNT = 5'd2;
	localparam logic [STEP_W-1:0] RESET_LEVEL_STEP  = 4'd1;
	localparam logic              RESET_REPEAT_MODE = 1'b0;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE = 2'd2;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_SHADE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  n;
		logic [CNT_W-1:0]  n_m1;
		logic [STEP_W-1:0] step;
		logic              rep;
	} cfg_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [2:0]         x3;
		logic [2:0]         y3;
		logic [SLOT_W-1:0]  slot;
		logic [COLOR_W-1:0] rgb;
	} item_t;

	typedef struct packed {
		item_t          item;
		logic [M_W-1:0] m;
		logic [P_W-1:0] p;
	} quant_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [CNT_W-1:0]   pick;
		logic [SLOT_W-1:0]  slot;
		logic [COLOR_W-1:0] rgb;
	} ram_req_t;

	localparam logic [STEP_RCP_W-1:0] STEP_RCP [16] = '{
		19'd0,      19'd262144, 19'd131072, 19'd87381,
		19'd65536,  19'd52428,  19'd43690,  19'd37449,
		19'd32768,  19'd29127,  19'd26214,  19'd23831,
		19'd21845,  19'd20164,  19'd18724,  19'd17476
	};

	localparam logic [WRAP_RCP_W-1:0] WRAP_RCP [32] = '{
		14'd0,    14'd8192, 14'd4096, 14'd2730, 14'd2048, 14'd1638, 14'd1365, 14'd1170,
		14'd1024, 14'd910,  14'd819,  14'd744,  14'd682,  14'd630,  14'd585,  14'd546,
		14'd512,  14'd481,  14'd455,  14'd431,  14'd409,  14'd390,  14'd372,  14'd356,
		14'd341,  14'd327,  14'd315,  14'd303,  14'd292,  14'd282,  14'd273,  14'd0
	};

	function automatic logic base_pattern(input logic [2:0] x8, input logic [2:0] y8,
	                                      input logic [LVL_W-1:0] lvl);
		logic [1:0] x4;
		logic [1:0] y4;
		logic       hit;
		x4 = x8[1:0];
		y4 = y8[1:0];
		case (lvl)
			4'd1: hit = (x8 == 3'd0 && y8 == 3'd0) || (x8 == 3'd4 && y8 == 3'd4);
			4'd2: hit = (x8 == 3'd0 && (y8 inside {3'd2, 3'd6})) ||
			            (x8 == 3'd4 && (y8 inside {3'd0, 3'd4}));
			4'd3: hit = (x4 == 2'd0 && y4 == 2'd0) || (x4 == 2'd2 && y4 == 2'd2);
			4'd4: hit = (x4 == 2'd0 && (y4 inside {2'd1, 2'd3})) ||
			            (x4 == 2'd2 && (y4 inside {2'd0, 2'd2}));
			4'd5: hit = (x4 == y4) || (({1'b0, x4} + {1'b0, y4}) == 3'd4);
			4'd6: hit = (x8[0] == y8[0]) && !(x8 == 3'd1 && y8 == 3'd5) &&
			            !(x8 == 3'd5 && y8 == 3'd1);
			4'd7: hit = (x8[0] == y8[0]);
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Upper levels mirror the lower ones, inverted and shifted one column
	function automatic logic shade_on(input logic [2:0] x8, input logic [2:0] y8,
	                                  input logic [LVL_W-1:0] lvl);
		logic hit;
		if (lvl <= 4'd7) begin
			hit = base_pattern(x8, y8, lvl);
		end else begin
			hit = !base_pattern(x8 + 3'd1, y8, LVL_W'(SHADE_LEVELS - 1) - lvl);
		end
		return hit;
	endfunction

endpackage

/* rtl/dgpp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module dgpp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/dgpp_quant.sv */
// ----------------------------------------------------------------------------
// Level quantizer
// Scale the distance, round by the level step and form m with its /15 product.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dgpp_quant (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dgpp_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  dgpp_pkg::item_t                in_item,
	input  logic [dgpp_pkg::DIST_W-1:0]    in_dist,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dgpp_pkg::quant_t               out_q
);

	localparam int KW    = dgpp_pkg::CNT_W + 4;
	localparam int EST_W = dgpp_pkg::T_W + dgpp_pkg::STEP_RCP_W;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;

	dgpp_pkg::item_t item_s1, item_s2, item_s3, item_s4, item_s5;

	logic [dgpp_pkg::NUM_W-1:0] num_s1;
	logic [dgpp_pkg::T_W-1:0]   t_s2;
	logic [EST_W-1:0]           est_s2;
	logic [dgpp_pkg::T_W-1:0]   q_s3;
	logic [dgpp_pkg::M_W-1:0]   m_s4, m_s5;
	logic [dgpp_pkg::P_W-1:0]   p_s5;

	logic [KW-1:0]              k1;
	logic [dgpp_pkg::NUM_W-1:0] num1;
	logic [dgpp_pkg::NUM_W-1:0] sum2;
	logic [dgpp_pkg::T_W-1:0]   t2;
	logic [EST_W-1:0]           est2;
	logic [dgpp_pkg::T_W-1:0]   st_ext;
	logic [dgpp_pkg::T_W-1:0]   q0_3, prod3, r3, q3;
	logic [dgpp_pkg::M_W-1:0]   m4;
	logic [dgpp_pkg::P_W-1:0]   p5;

	// Collapse bubbles: a stage loads when empty or when it drains
	assign ld_s5    = !valid_s5 || out_ready;
	assign ld_s4    = !valid_s4 || ld_s5;
	assign ld_s3    = !valid_s3 || ld_s4;
	assign ld_s2    = !valid_s2 || ld_s3;
	assign ld_s1    = !valid_s1 || ld_s2;
	assign in_ready = ld_s1;

	assign st_ext = {{(dgpp_pkg::T_W - dgpp_pkg::STEP_W){1'b0}}, cfg.step};

	always_comb begin
		k1   = {cfg.n_m1, 4'b0000} - {4'b0000, cfg.n_m1};
		num1 = {{(dgpp_pkg::NUM_W - dgpp_pkg::DIST_W){1'b0}}, in_dist} *
		       {{(dgpp_pkg::NUM_W - KW){1'b0}}, k1};
		sum2 = num_s1 + (dgpp_pkg::NUM_W'(cfg.step) << dgpp_pkg::RND_SHIFT);
		t2   = sum2[dgpp_pkg::NUM_W-1:dgpp_pkg::FRAC_W];
		est2 = {{dgpp_pkg::STEP_RCP_W{1'b0}}, t2} *
		       {{dgpp_pkg::T_W{1'b0}}, dgpp_pkg::STEP_RCP[cfg.step]};
		q0_3  = est_s2[dgpp_pkg::STEP_RCP_K +: dgpp_pkg::T_W];
		prod3 = q0_3 * st_ext;
		r3    = t_s2 - prod3;
		q3    = q0_3 + dgpp_pkg::T_W'(r3 >= st_ext);
		m4    = q_s3 * st_ext;
		p5    = {{dgpp_pkg::INV15_W{1'b0}}, m_s4} *
		        {{dgpp_pkg::M_W{1'b0}}, dgpp_pkg::INV15};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ld_s1) valid_s1 <= in_valid;
			if (ld_s2) valid_s2 <= valid_s1;
			if (ld_s3) valid_s3 <= valid_s2;
			if (ld_s4) valid_s4 <= valid_s3;
			if (ld_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1 <= in_item;
			num_s1  <= num1;
		end
		if (ld_s2) begin
			item_s2 <= item_s1;
			t_s2    <= t2;
			est_s2  <= est2;
		end
		if (ld_s3) begin
			item_s3 <= item_s2;
			q_s3    <= q3;
		end
		if (ld_s4) begin
			item_s4 <= item_s3;
			m_s4    <= m4;
		end
		if (ld_s5) begin
			item_s5 <= item_s4;
			m_s5    <= m_s4;
			p_s5    <= p5;
		end
	end

	assign out_valid  = valid_s5;
	assign out_q.item = item_s5;
	assign out_q.m    = m_s5;
	assign out_q.p    = p_s5;

	// The step reciprocal may undershoot the quotient by one, never more
	`ASSERT_CLK(a_step_quot_err, valid_s2 |-> (r3 < (st_ext << 1)), "step quotient off by more than one")

endmodule

/* rtl/dgpp_pick.sv */
// ----------------------------------------------------------------------------
// Palette index picker
// Split m into index and shade level, apply the dither, then wrap or clamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dgpp_pick (
	input  logic                clk,
	input  logic                arst_n,
	input  dgpp_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  dgpp_pkg::quant_t    in_q,
	output logic                out_valid,
	input  logic                out_ready,
	output dgpp_pkg::ram_req_t  out_req
);

	localparam int EST_W = dgpp_pkg::IDX_W + dgpp_pkg::WRAP_RCP_W;

	logic valid_s6, valid_s7;
	logic ld_s6, ld_s7;

	dgpp_pkg::item_t            item_s6;
	logic [dgpp_pkg::IDX_W-1:0] idx_s6;
	logic                       shade_s6;
	logic [EST_W-1:0]           est_s6;
	dgpp_pkg::ram_req_t         req_s7;

	logic [dgpp_pkg::IDX_W-1:0] idx6;
	logic [dgpp_pkg::M_W-1:0]   lvl_full6;
	logic [dgpp_pkg::LVL_W-1:0] lvl6;
	logic                       shade6;
	logic [EST_W-1:0]           est6;

	logic [dgpp_pkg::IDX_W-1:0] d7, q0_7, prod7, r7, rem7;
	logic [dgpp_pkg::IDX_W:0]   next7;
	logic [dgpp_pkg::CNT_W-1:0] pick7;

	assign ld_s7    = !valid_s7 || out_ready;
	assign ld_s6    = !valid_s6 || ld_s7;
	assign in_ready = ld_s6;

	always_comb begin
		idx6      = in_q.p[dgpp_pkg::INV15_K +: dgpp_pkg::IDX_W];
		lvl_full6 = in_q.m - dgpp_pkg::M_W'(idx6) * dgpp_pkg::M_W'(dgpp_pkg::SHADE_LEVELS);
		lvl6      = lvl_full6[dgpp_pkg::LVL_W-1:0];
		shade6    = dgpp_pkg::shade_on(in_q.item.x3, in_q.item.y3, lvl6);
		est6      = {{dgpp_pkg::WRAP_RCP_W{1'b0}}, idx6} *
		            {{dgpp_pkg::IDX_W{1'b0}}, dgpp_pkg::WRAP_RCP[cfg.n_m1]};
	end

	// Wrap remainder: reciprocal estimate, then one correction
	always_comb begin
		d7    = {{(dgpp_pkg::IDX_W - dgpp_pkg::CNT_W){1'b0}}, cfg.n_m1};
		q0_7  = est_s6[dgpp_pkg::WRAP_RCP_K +: dgpp_pkg::IDX_W];
		prod7 = q0_7 * d7;
		r7    = idx_s6 - prod7;
		rem7  = (r7 >= d7) ? (r7 - d7) : r7;
		next7 = {1'b0, idx_s6} + (dgpp_pkg::IDX_W + 1)'(1);
		if (cfg.rep) begin
			pick7 = dgpp_pkg::CNT_W'(rem7) + dgpp_pkg::CNT_W'(shade_s6);
		end else if (next7 >= {{(dgpp_pkg::IDX_W + 1 - dgpp_pkg::CNT_W){1'b0}}, cfg.n}) begin
			pick7 = cfg.n_m1;
		end else begin
			pick7 = dgpp_pkg::CNT_W'(idx_s6) + dgpp_pkg::CNT_W'(shade_s6);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (ld_s6) valid_s6 <= in_valid;
			if (ld_s7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			item_s6  <= in_q.item;
			idx_s6   <= idx6;
			shade_s6 <= shade6;
			est_s6   <= est6;
		end
		if (ld_s7) begin
			req_s7.cmd  <= item_s6.cmd;
			req_s7.pick <= pick7;
			req_s7.slot <= item_s6.slot;
			req_s7.rgb  <= item_s6.rgb;
		end
	end

	assign out_valid = valid_s7;
	assign out_req   = req_s7;

	`ASSERT_CLK(a_level_range, in_valid |-> (lvl_full6 < dgpp_pkg::M_W'(dgpp_pkg::SHADE_LEVELS)), "shade level out of range")
	`ASSERT_NEVER(a_pick_range, valid_s7 && req_s7.cmd == dgpp_pkg::CMD_SHADE && req_s7.pick >= cfg.n, "palette pick past colour count")

endmodule

/* rtl/dithered_gradient_palette_pick.sv */
// ----------------------------------------------------------------------------
// Dithered gradient palette pick
// Maps a pixel's normalized gradient distance (unsigned Q8.16) to an RGB888
// palette colour, ordered-dithering between neighbouring palette entries on
// fifteen shade levels. A transaction with command 0 loads entry_color into
// palette slot entry_index and returns nothing; command 1 shades the pixel
// at (pixel_x, pixel_y) and returns one colour. One transaction is taken
// every clock while results are not stalled; a shade result passes through
// seven arithmetic stages (scale, step reciprocal, step correction, rescale,
// divide by fifteen, level and wrap reciprocal, wrap correction and pick)
// and then the registered read of the palette RAM. Loads write the RAM at the
// same point where shades read it, so results follow transaction order.
// Results stall in place when out_ready is low; bubbles still absorb new
// transactions. Read only palette entries that were loaded. Write the
// configuration registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dithered_gradient_palette_pick #(
	parameter int PALETTE_DEPTH = dgpp_pkg::DEFAULT_PALETTE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [dgpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dgpp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [dgpp_pkg::COORD_W-1:0]       pixel_x,
	input  logic [dgpp_pkg::COORD_W-1:0]       pixel_y,
	input  logic [dgpp_pkg::DIST_W-1:0]        distance,
	input  logic [dgpp_pkg::SLOT_W-1:0]        entry_index,
	input  logic [dgpp_pkg::COLOR_W-1:0]       entry_color,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dgpp_pkg::COLOR_W-1:0]       color
);

	localparam int ADDR_W = $clog2(PALETTE_DEPTH);

	logic [dgpp_pkg::CNT_W-1:0]  color_count_q;
	logic [dgpp_pkg::STEP_W-1:0] level_step_q;
	logic                        repeat_mode_q;

	dgpp_pkg::cfg_t     cfg;
	dgpp_pkg::item_t    in_item;
	dgpp_pkg::quant_t   quant;
	dgpp_pkg::ram_req_t req;

	logic quant_valid, quant_ready;
	logic req_valid, req_ready;
	logic valid_s8, ld_s8;
	logic slot_ok;
	logic ram_we, ram_re;

	// Configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= dgpp_pkg::RESET_COLOR_COUNT;
			level_step_q  <= dgpp_pkg::RESET_LEVEL_STEP;
			repeat_mode_q <= dgpp_pkg::RESET_REPEAT_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				dgpp_pkg::REG_COLOR_COUNT: color_count_q <= cfg_wdata;
				dgpp_pkg::REG_LEVEL_STEP:  level_step_q  <= cfg_wdata[dgpp_pkg::STEP_W-1:0];
				dgpp_pkg::REG_REPEAT_MODE: repeat_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Saturate the colour count into [2, depth] and treat a zero step as one
	always_comb begin
		if (color_count_q < dgpp_pkg::CNT_W'(dgpp_pkg::MIN_COLORS)) begin
			cfg.n = dgpp_pkg::CNT_W'(dgpp_pkg::MIN_COLORS);
		end else if (32'(color_count_q) > PALETTE_DEPTH) begin
			cfg.n = dgpp_pkg::CNT_W'(PALETTE_DEPTH);
		end else begin
			cfg.n = color_count_q;
		end
		cfg.n_m1 = cfg.n - dgpp_pkg::CNT_W'(1);
		cfg.step = (level_step_q == '0) ? dgpp_pkg::STEP_W'(1) : level_step_q;
		cfg.rep  = repeat_mode_q;
	end

	// Only the low three coordinate bits matter to the 8x8 and 4x4 patterns
	always_comb begin
		in_item.cmd  = dgpp_pkg::cmd_t'(command);
		in_item.x3   = pixel_x[2:0];
		in_item.y3   = pixel_y[2:0];
		in_item.slot = entry_index;
		in_item.rgb  = entry_color;
	end

	dgpp_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.in_dist   (distance),
		.out_valid (quant_valid),
		.out_ready (quant_ready),
		.out_q     (quant)
	);

	dgpp_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (quant_valid),
		.in_ready  (quant_ready),
		.in_q      (quant),
		.out_valid (req_valid),
		.out_ready (req_ready),
		.out_req   (req)
	);

	// RAM access stage: loads retire here, shades move into the read register
	assign slot_ok   = {{(32 - dgpp_pkg::SLOT_W){1'b0}}, req.slot} < 32'(PALETTE_DEPTH);
	assign ld_s8     = !valid_s8 || out_ready;
	assign req_ready = (req.cmd == dgpp_pkg::CMD_LOAD) || ld_s8;
	assign ram_we    = req_valid && (req.cmd == dgpp_pkg::CMD_LOAD) && slot_ok;
	assign ram_re    = req_valid && (req.cmd == dgpp_pkg::CMD_SHADE) && ld_s8;

	dgpp_ram #(
		.WIDTH (dgpp_pkg::COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(req.slot)),
		.wdata (req.rgb),
		.re    (ram_re),
		.raddr (ADDR_W'(req.pick)),
		.rdata (color)
	);

	// Hold the read data as the result until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (ld_s8) begin
			valid_s8 <= req_valid && (req.cmd == dgpp_pkg::CMD_SHADE);
		end
	end

	assign out_valid = valid_s8;

	`ASSERT_CLK(a_read_gives_result, ram_re |=> valid_s8, "palette read did not produce a result")
	`ASSERT_NEVER(a_load_past_depth, ram_we && !slot_ok, "palette write outside depth")

endmodule
